FILE: rtl/core/gfd_pkg.sv
// shared types and constants of the gyro flick detector
package gfd_pkg;

  localparam int unsigned RateW    = 16;
  localparam int unsigned MagW     = RateW + 1;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned CoolW    = 24;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DirW     = 2;

  // thresholds are in dps, samples in counts: 16 counts per dps
  localparam int unsigned CountsShift = 4;

  localparam logic [ThrW-1:0]  HighThrRst  = 12'd300;
  localparam logic [ThrW-1:0]  LowThrRst   = 12'd100;
  localparam logic [CoolW-1:0] CooldownRst = 24'd500000;

  localparam logic [DirW-1:0] FlickNone = 2'b00;
  localparam logic [DirW-1:0] FlickPos  = 2'b01;
  localparam logic [DirW-1:0] FlickNeg  = 2'b11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_COOLDOWN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            neg;
  } peak_t;

endpackage

FILE: rtl/core/gfd_peak.sv
// peak axis selection: largest magnitude of three axes, earlier axis wins ties
module gfd_peak (
  input  logic signed [gfd_pkg::RateW-1:0] rate_x_i,
  input  logic signed [gfd_pkg::RateW-1:0] rate_y_i,
  input  logic signed [gfd_pkg::RateW-1:0] rate_z_i,
  output gfd_pkg::peak_t                   peak_o
);

  logic [gfd_pkg::MagW-1:0] mag_x, mag_y, mag_z;
  gfd_pkg::peak_t           pick_xy;

  function automatic logic [gfd_pkg::MagW-1:0] mag_of(logic signed [gfd_pkg::RateW-1:0] v);
    logic [gfd_pkg::MagW-1:0] ext;
    ext = {v[gfd_pkg::RateW-1], v};
    return v[gfd_pkg::RateW-1] ? (~ext + 1'b1) : ext;
  endfunction

  assign mag_x = mag_of(rate_x_i);
  assign mag_y = mag_of(rate_y_i);
  assign mag_z = mag_of(rate_z_i);

  always_comb begin
    if (mag_y > mag_x) begin
      pick_xy.mag = mag_y;
      pick_xy.neg = rate_y_i[gfd_pkg::RateW-1];
    end else begin
      pick_xy.mag = mag_x;
      pick_xy.neg = rate_x_i[gfd_pkg::RateW-1];
    end
    if (mag_z > pick_xy.mag) begin
      peak_o.mag = mag_z;
      peak_o.neg = rate_z_i[gfd_pkg::RateW-1];
    end else begin
      peak_o = pick_xy;
    end
  end

endmodule

FILE: rtl/core/gyro_flick_detector.sv
// gyro flick detector top level
//
// Input channel: in_valid_i / in_stall_o with three signed rate axes, a
// microsecond timestamp and a sample_ok flag. Output channel: out_valid_o /
// out_stall_i carrying flick_dir_o (0 none, +1 positive, -1 negative). Every
// accepted item produces exactly one result item.
// Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
// index 0 high threshold, 1 low threshold, 2 cooldown, others ignored. Writes
// are always taken and are meant to happen while the block is idle.
// From input accept to result valid an item passes an input register, then
// the peak select and threshold/cooldown checks, which update the armed flag
// and last flick time and load the result register. One item per cycle is
// sustained while the receiver does not stall; the armed/time state is
// updated in the same cycle as the decision so the next item sees it directly.
// When the receiver stalls, the result holds; the input register takes one
// more item only if empty, then in_stall_o rises until the result leaves.
// Reset clears both stages, re-arms the detector, zeroes the last flick time
// and loads the default thresholds and cooldown.
module gyro_flick_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gfd_pkg::RateW-1:0]    rate_x_i,
  input  logic signed [gfd_pkg::RateW-1:0]    rate_y_i,
  input  logic signed [gfd_pkg::RateW-1:0]    rate_z_i,
  input  logic        [gfd_pkg::TimeW-1:0]    time_us_i,
  input  logic                                sample_ok_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gfd_pkg::DirW-1:0]     flick_dir_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [gfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [gfd_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [gfd_pkg::ThrW-1:0]  high_thr_q, low_thr_q;
  logic [gfd_pkg::CoolW-1:0] cooldown_q;

  logic                            s1_valid_q;
  logic signed [gfd_pkg::RateW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [gfd_pkg::TimeW-1:0]       s1_time_q;
  logic                            s1_ok_q;

  logic                      armed_q, armed_d;
  logic [gfd_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic                      out_valid_q;
  logic [gfd_pkg::DirW-1:0]  dir_q, dir_d;

  logic                      out_free, s1_load, s1_fire;
  gfd_pkg::peak_t            peak;
  logic [gfd_pkg::MagW-1:0]  high_cnt, low_cnt;
  logic [gfd_pkg::TimeW-1:0] elapsed;
  logic                      cool, rearm, fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= gfd_pkg::HighThrRst;
      low_thr_q  <= gfd_pkg::LowThrRst;
      cooldown_q <= gfd_pkg::CooldownRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gfd_pkg::REG_HIGH_THR: high_thr_q <= cfg_data_i[gfd_pkg::ThrW-1:0];
        gfd_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data_i[gfd_pkg::ThrW-1:0];
        gfd_pkg::REG_COOLDOWN: cooldown_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_x_q    <= rate_x_i;
      s1_y_q    <= rate_y_i;
      s1_z_q    <= rate_z_i;
      s1_time_q <= time_us_i;
      s1_ok_q   <= sample_ok_i;
    end
  end

  gfd_peak u_peak (
    .rate_x_i (s1_x_q),
    .rate_y_i (s1_y_q),
    .rate_z_i (s1_z_q),
    .peak_o   (peak)
  );

  assign high_cnt = {1'b0, high_thr_q, {gfd_pkg::CountsShift{1'b0}}};
  assign low_cnt  = {1'b0, low_thr_q, {gfd_pkg::CountsShift{1'b0}}};
  assign elapsed  = s1_time_q - last_time_q;
  assign cool     = (s1_time_q > last_time_q) &&
                    (elapsed > {{(gfd_pkg::TimeW-gfd_pkg::CoolW){1'b0}}, cooldown_q});
  // re-arm takes effect before the fire check of the same item
  assign rearm    = s1_ok_q && (peak.mag < low_cnt);
  assign fire     = s1_ok_q && (armed_q || rearm) && (peak.mag > high_cnt) && cool;

  always_comb begin
    armed_d     = armed_q;
    last_time_d = last_time_q;
    dir_d       = gfd_pkg::FlickNone;
    if (rearm) begin
      armed_d = 1'b1;
    end
    if (fire) begin
      armed_d     = 1'b0;
      last_time_d = s1_time_q;
      dir_d       = peak.neg ? gfd_pkg::FlickNeg : gfd_pkg::FlickPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b1;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        armed_q     <= armed_d;
        last_time_q <= last_time_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      dir_q <= dir_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flick_dir_o = dir_q;

endmodule

FILE: rtl/core/gfd_checker.sv
// port-level checker for the gyro flick detector, bound to the top level
module gfd_assert_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [gfd_pkg::DirW-1:0]        flick_dir_o
);

  // a result never carries the unused direction code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flick_dir_o == gfd_pkg::FlickNone ||
                     flick_dir_o == gfd_pkg::FlickPos ||
                     flick_dir_o == gfd_pkg::FlickNeg))
    else $error("flick_dir_o carries an invalid code");

  // input side only backs up when a result is stuck at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(flick_dir_o)))
    else $error("stalled result changed");

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind gyro_flick_detector gfd_assert_checker u_gfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .flick_dir_o (flick_dir_o)
);
